// File: sv/r2fft_pkg.sv
// shared constants and types of the radix-2 fft unit
`default_nettype none
package r2fft_pkg;

  localparam int LOG2_POINTS = 10;
  localparam int NPTS        = 1 << LOG2_POINTS;
  localparam int HALF_NPTS   = NPTS >> 1;
  localparam int ADDR_W      = LOG2_POINTS;
  localparam int TW_W        = LOG2_POINTS - 1;
  localparam int STG_W       = $clog2(LOG2_POINTS);
  localparam int DW          = 27;
  localparam int WORD_W      = 2 * DW;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [0:0] REG_NO_SCALE = 1'd0;
  localparam logic [0:0] REG_INVERSE  = 1'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_REV_RD_I,
    ST_REV_RD_R,
    ST_REV_WR_I,
    ST_REV_WR_R,
    ST_BF_RD_A,
    ST_BF_RD_B,
    ST_BF_MUL,
    ST_BF_ADD,
    ST_BF_WR_A,
    ST_BF_WR_B
  } state_t;

  typedef enum logic [2:0] {
    WSEL_SAMPLE,
    WSEL_RDATA,
    WSEL_REGA,
    WSEL_SUM,
    WSEL_DIFF
  } wsel_t;

  typedef struct packed {
    logic [ADDR_W-1:0] ram_addr;
    logic              ram_we;
    wsel_t             wr_sel;
    logic              ld_a;
    logic [TW_W-1:0]   tw_addr;
    logic              mul_en;
    logic              add_en;
    logic              halve;
    logic              out_load;
    logic [ADDR_W-1:0] out_idx;
    logic              out_last;
  } cmd_t;

endpackage
`default_nettype wire

// File: sv/r2fft_ram.sv
// generic single-port ram with registered read
`default_nettype none
module r2fft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

// File: sv/r2fft_twiddle.sv
// twiddle rom: q15 cosine and sine, registered read
`default_nettype none
module r2fft_twiddle
  import r2fft_pkg::*;
(
  input  wire logic            clk,
  input  wire logic [TW_W-1:0] addr,
  output logic      [31:0]     rdata
);

  typedef logic [31:0] tw_rom_t [HALF_NPTS];

  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint          ONE_Q30 = 64'sd1 << 30;

  function automatic logic [15:0] q30_to_q15(input longint v);
    longint          t;
    longint unsigned r;
    t = v;
    if (t < 0) t = 0;
    if (t > ONE_Q30) t = ONE_Q30;
    r = (longint'(t) + 64'd16384) >> 15;
    if (r > 64'd32767) r = 64'd32767;
    return r[15:0];
  endfunction

  // shift and subtract quotient, floor of num / den, evaluated at elaboration
  function automatic longint unsigned udiv(input longint unsigned num,
                                           input longint unsigned den);
    longint unsigned q, rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem  = rem - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic tw_rom_t build_rom();
    tw_rom_t         rom;
    longint unsigned a, x2, tc, ts, m;
    longint          sc, ss;
    logic [15:0]     cq, sq;
    logic            upper;
    for (int k = 0; k < HALF_NPTS; k++) begin
      upper = k > (NPTS >> 2);
      m  = upper ? longint'(HALF_NPTS - k) : longint'(k);
      a  = (PI_Q30 * 2 * m) >> LOG2_POINTS;
      x2 = (a * a) >> 30;
      tc = ONE_Q30;
      ts = a;
      sc = ONE_Q30;
      ss = longint'(a);
      for (int n = 1; n <= 8; n++) begin
        tc = udiv((tc * x2) >> 30, 64'((2 * n - 1) * (2 * n)));
        ts = udiv((ts * x2) >> 30, 64'((2 * n) * (2 * n + 1)));
        if (n[0]) begin
          sc = sc - longint'(tc);
          ss = ss - longint'(ts);
        end else begin
          sc = sc + longint'(tc);
          ss = ss + longint'(ts);
        end
      end
      cq = q30_to_q15(sc);
      sq = q30_to_q15(ss);
      if (upper) cq = 16'(17'h10000 - {1'b0, cq});
      rom[k] = {cq, sq};
    end
    return rom;
  endfunction

  localparam tw_rom_t TW_ROM = build_rom();

  always_ff @(posedge clk) begin
    rdata <= TW_ROM[addr];
  end

endmodule
`default_nettype wire

// File: sv/r2fft_datapath.sv
// datapath: sample store, twiddle rom, butterfly arithmetic, result register
`default_nettype none
module r2fft_datapath
  import r2fft_pkg::*;
(
  input  wire logic                 clk,
  input  wire cmd_t                 cmd,
  input  wire logic signed [15:0]   sample_re,
  input  wire logic signed [15:0]   sample_im,
  output logic signed [DW-1:0]      out_re,
  output logic signed [DW-1:0]      out_im,
  output logic        [ADDR_W-1:0]  bin_index,
  output logic                      last
);

  localparam int PW = DW + 16;

  logic [WORD_W-1:0] wdata, rdata, reg_a;
  logic [31:0]       tw;
  logic signed [PW-1:0] p_rc, p_is, p_ic, p_rs;
  logic signed [DW-1:0] sum_re, sum_im, diff_re, diff_im;
  logic signed [DW-1:0] sum_re_next, sum_im_next, diff_re_next, diff_im_next;

  r2fft_ram #(.WIDTH(WORD_W), .DEPTH(NPTS)) u_store (
    .clk   (clk),
    .we    (cmd.ram_we),
    .addr  (cmd.ram_addr),
    .wdata (wdata),
    .rdata (rdata)
  );

  r2fft_twiddle u_tw (
    .clk   (clk),
    .addr  (cmd.tw_addr),
    .rdata (tw)
  );

  function automatic logic signed [DW-1:0] sat27(input logic signed [DW+2:0] v);
    if (v > (DW+3)'((1 <<< (DW-1)) - 1)) return {1'b0, {(DW-1){1'b1}}};
    if (v < -(DW+3)'(1 <<< (DW-1)))      return {1'b1, {(DW-1){1'b0}}};
    return v[DW-1:0];
  endfunction

  always_comb begin
    unique case (cmd.wr_sel)
      WSEL_SAMPLE: wdata = {DW'(sample_re), DW'(sample_im)};
      WSEL_RDATA:  wdata = rdata;
      WSEL_REGA:   wdata = reg_a;
      WSEL_SUM:    wdata = {sum_re, sum_im};
      WSEL_DIFF:   wdata = {diff_re, diff_im};
      default:     wdata = rdata;
    endcase
  end

  always_comb begin
    logic signed [PW:0]   tr_full, ti_full;
    logic signed [DW+1:0] tr, ti;
    logic signed [DW+2:0] sr, si, dr, di;
    logic signed [DW-1:0] ar, ai;
    tr_full = PW'(p_rc) + PW'(p_is);
    ti_full = PW'(p_ic) - PW'(p_rs);
    tr = tr_full[PW:15];
    ti = ti_full[PW:15];
    ar = reg_a[WORD_W-1:DW];
    ai = reg_a[DW-1:0];
    sr = (DW+3)'(ar) + (DW+3)'(tr);
    si = (DW+3)'(ai) + (DW+3)'(ti);
    dr = (DW+3)'(ar) - (DW+3)'(tr);
    di = (DW+3)'(ai) - (DW+3)'(ti);
    if (cmd.halve) begin
      sr = sr >>> 1;
      si = si >>> 1;
      dr = dr >>> 1;
      di = di >>> 1;
    end
    sum_re_next  = sat27(sr);
    sum_im_next  = sat27(si);
    diff_re_next = sat27(dr);
    diff_im_next = sat27(di);
  end

  always_ff @(posedge clk) begin
    logic signed [DW-1:0] br, bi;
    logic signed [15:0]   c, s;
    br = rdata[WORD_W-1:DW];
    bi = rdata[DW-1:0];
    c  = tw[31:16];
    s  = tw[15:0];
    if (cmd.ld_a) begin
      reg_a <= rdata;
    end
    if (cmd.mul_en) begin
      p_rc <= br * c;
      p_is <= bi * s;
      p_ic <= bi * c;
      p_rs <= br * s;
    end
    if (cmd.add_en) begin
      sum_re  <= sum_re_next;
      sum_im  <= sum_im_next;
      diff_re <= diff_re_next;
      diff_im <= diff_im_next;
    end
    if (cmd.out_load) begin
      out_re    <= rdata[WORD_W-1:DW];
      out_im    <= rdata[DW-1:0];
      bin_index <= cmd.out_idx;
      last      <= cmd.out_last;
    end
  end

endmodule
`default_nettype wire

// File: sv/r2fft_ctrl.sv
// controller: handshakes, counters, address sequencing of reorder and stages
`default_nettype none
module r2fft_ctrl
  import r2fft_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       opcode,
  output logic            out_valid,
  input  wire logic       out_stall,
  input  wire logic       cfg_we,
  input  wire logic [0:0] cfg_index,
  input  wire logic [0:0] cfg_data,
  output cmd_t            cmd
);

  state_t state, state_next;
  logic [ADDR_W-1:0] load_count, read_count, rev_i, rev_r, rd_idx;
  logic [ADDR_W-1:0] addr_a, addr_b;
  logic [TW_W-1:0]   bf_k, bf_j;
  logic [STG_W-1:0]  stg;
  logic frame_ready, no_scale, inverse_mode, halve;
  logic acc, bf_last_k, bf_last_stg;

  function automatic logic [ADDR_W-1:0] rev_bits(input logic [ADDR_W-1:0] v);
    logic [ADDR_W-1:0] r;
    for (int b = 0; b < ADDR_W; b++) r[ADDR_W-1-b] = v[b];
    return r;
  endfunction

  assign in_stall    = (state != ST_IDLE) || (out_valid && out_stall);
  assign acc         = in_valid && !in_stall;
  assign rev_r       = rev_bits(rev_i);
  assign bf_j        = bf_k & TW_W'((TW_W'(1) << stg) - TW_W'(1));
  assign addr_a      = ADDR_W'(((ADDR_W'(bf_k) >> stg) << (stg + 1))) | ADDR_W'(bf_j);
  assign addr_b      = addr_a | (ADDR_W'(1) << stg);
  assign bf_last_k   = bf_k == TW_W'(HALF_NPTS - 1);
  assign bf_last_stg = stg == STG_W'(LOG2_POINTS - 1);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (acc) begin
          if (opcode == OP_LOAD) begin
            if (load_count == ADDR_W'(NPTS - 1)) state_next = ST_REV_RD_I;
          end else if (frame_ready) begin
            state_next = ST_READ;
          end
        end
      end
      ST_READ:     state_next = ST_IDLE;
      ST_REV_RD_I: begin
        if (rev_i < rev_r) state_next = ST_REV_RD_R;
        else if (rev_i == ADDR_W'(NPTS - 1)) state_next = ST_BF_RD_A;
      end
      ST_REV_RD_R: state_next = ST_REV_WR_I;
      ST_REV_WR_I: state_next = ST_REV_WR_R;
      ST_REV_WR_R: state_next = (rev_i == ADDR_W'(NPTS - 1)) ? ST_BF_RD_A : ST_REV_RD_I;
      ST_BF_RD_A:  state_next = ST_BF_RD_B;
      ST_BF_RD_B:  state_next = ST_BF_MUL;
      ST_BF_MUL:   state_next = ST_BF_ADD;
      ST_BF_ADD:   state_next = ST_BF_WR_A;
      ST_BF_WR_A:  state_next = ST_BF_WR_B;
      ST_BF_WR_B:  state_next = (bf_last_k && bf_last_stg) ? ST_IDLE : ST_BF_RD_A;
      default:     state_next = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd          = '0;
    cmd.wr_sel   = WSEL_SAMPLE;
    cmd.halve    = halve;
    cmd.tw_addr  = TW_W'(bf_j << (STG_W'(LOG2_POINTS - 1) - stg));
    cmd.out_idx  = rd_idx;
    cmd.out_last = rd_idx == ADDR_W'(NPTS - 1);
    unique case (state)
      ST_IDLE: begin
        cmd.ram_addr = (opcode == OP_LOAD) ? load_count : read_count;
        cmd.ram_we   = acc && (opcode == OP_LOAD);
      end
      ST_READ:     cmd.out_load = 1'b1;
      ST_REV_RD_I: cmd.ram_addr = rev_i;
      ST_REV_RD_R: begin
        cmd.ram_addr = rev_r;
        cmd.ld_a     = 1'b1;
      end
      ST_REV_WR_I: begin
        cmd.ram_addr = rev_i;
        cmd.ram_we   = 1'b1;
        cmd.wr_sel   = WSEL_RDATA;
      end
      ST_REV_WR_R: begin
        cmd.ram_addr = rev_r;
        cmd.ram_we   = 1'b1;
        cmd.wr_sel   = WSEL_REGA;
      end
      ST_BF_RD_A:  cmd.ram_addr = addr_a;
      ST_BF_RD_B: begin
        cmd.ram_addr = addr_b;
        cmd.ld_a     = 1'b1;
      end
      ST_BF_MUL:   cmd.mul_en = 1'b1;
      ST_BF_ADD:   cmd.add_en = 1'b1;
      ST_BF_WR_A: begin
        cmd.ram_addr = addr_a;
        cmd.ram_we   = 1'b1;
        cmd.wr_sel   = WSEL_SUM;
      end
      ST_BF_WR_B: begin
        cmd.ram_addr = addr_b;
        cmd.ram_we   = 1'b1;
        cmd.wr_sel   = WSEL_DIFF;
      end
      default: cmd.ram_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      load_count   <= '0;
      read_count   <= '0;
      frame_ready  <= 1'b0;
      no_scale     <= 1'b0;
      inverse_mode <= 1'b0;
      halve        <= 1'b1;
      rev_i        <= '0;
      bf_k         <= '0;
      stg          <= '0;
      out_valid    <= 1'b0;
      rd_idx       <= '0;
    end else begin
      state <= state_next;
      if (cfg_we && cfg_index == REG_NO_SCALE) no_scale <= cfg_data[0];
      if (cfg_we && cfg_index == REG_INVERSE) inverse_mode <= cfg_data[0];

      if (state == ST_READ) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;

      if (state == ST_IDLE && acc) begin
        if (opcode == OP_LOAD) begin
          frame_ready <= 1'b0;
          read_count  <= '0;
          load_count  <= load_count + ADDR_W'(1);
          if (load_count == ADDR_W'(NPTS - 1)) begin
            // settings in force on the filling load hold for the whole frame
            halve <= !(no_scale || inverse_mode);
            rev_i <= '0;
            bf_k  <= '0;
            stg   <= '0;
          end
        end else if (frame_ready) begin
          rd_idx <= read_count;
          if (read_count == ADDR_W'(NPTS - 1)) begin
            frame_ready <= 1'b0;
            read_count  <= '0;
          end else begin
            read_count <= read_count + ADDR_W'(1);
          end
        end
      end

      if ((state == ST_REV_RD_I && !(rev_i < rev_r)) || state == ST_REV_WR_R) begin
        rev_i <= rev_i + ADDR_W'(1);
      end

      if (state == ST_BF_WR_B) begin
        if (bf_last_k) begin
          bf_k <= '0;
          if (bf_last_stg) begin
            frame_ready <= 1'b1;
            read_count  <= '0;
          end else begin
            stg <= stg + STG_W'(1);
          end
        end else begin
          bf_k <= bf_k + TW_W'(1);
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: sv/radix2_fft_in_place_unit.sv
// top level of the in-place radix-2 fft unit
`default_nettype none
// 1024-point in-place radix-2 decimation-in-time fft on complex q15 samples.
// a load transaction writes one sample to the store; the load that fills the
// last address starts the transform, during which input is stalled: a
// bit-reverse pass (read i, read r, write i, write r for each of the 496
// swapped pairs, a single read for every other address) and ten stages of
// 512 butterflies (read a, read b, multiply, add, write a, write b) on the
// single-port sample store. a read transaction's bin is taken from the store
// and then offered through the result register, with last set on bin 1023;
// input is also stalled while that result waits. a read with no frame ready
// gives no result. scaling by one half per stage is on unless no_scale or
// inverse_mode was set at the filling load.
module radix2_fft_in_place_unit
  import r2fft_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                opcode,
  input  wire logic signed [15:0]  sample_re,
  input  wire logic signed [15:0]  sample_im,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic signed [DW-1:0]     out_re,
  output logic signed [DW-1:0]     out_im,
  output logic        [ADDR_W-1:0] bin_index,
  output logic                     last,
  input  wire logic                cfg_we,
  input  wire logic [0:0]          cfg_index,
  input  wire logic [0:0]          cfg_data
);

  cmd_t cmd;

  r2fft_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd)
  );

  r2fft_datapath u_dp (
    .clk       (clk),
    .cmd       (cmd),
    .sample_re (sample_re),
    .sample_im (sample_im),
    .out_re    (out_re),
    .out_im    (out_im),
    .bin_index (bin_index),
    .last      (last)
  );

endmodule
`default_nettype wire
